/* src/assert_macros.svh */
// Assertion macros for the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define PTLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define PTLP_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ptlp_pkg.sv */
// Package for the point-to-line projection block: payload types, widths,
// register codes and pipeline sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptlp_pkg;

  // Fixed point format of all coordinates.
  localparam int FRAC_BITS = 16;

  // Datapath widths.
  localparam int NUM_W     = 96;  // signed numerators of the foot
  localparam int DEN_W     = 64;  // slope squared plus one
  localparam int REM_W     = 63;  // division remainder, always below the divisor
  localparam int QB        = 33;  // quotient bits resolved by the divider
  localparam int MSQ_SPLIT = 32;  // split point of slope squared for the multiply
  localparam int SUM_W     = 66;  // sum of squared distances
  localparam int ROOT_W    = 33;  // integer root
  localparam int SREM_W    = 36;  // square root remainder
  localparam int SQ        = SUM_W / 2;

  // Pipeline: five front stages, divider (with its load stage), four middle
  // stages, square root (with its load stage).
  localparam int N_STAGES  = 5 + (QB + 1) + 4 + (SQ + 1);

  // Configuration port.
  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_VERTICAL = 2'd0,
    REG_SLOPE    = 2'd1,
    REG_OFFSET   = 2'd2
  } cfg_reg_t;

  // One input transaction.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic        [31:0] point_distance;
  } out_item_t;

endpackage

`default_nettype wire

/* src/point_to_line_projection.sv */
// Top level of the point-to-line projection block: configuration registers
// and the full arithmetic pipeline. Depends on ptlp_pkg.
//
// Usage:
//   The line is set through the cfg_ APB-style port: line_vertical at byte
//   address 0, line_slope at 4, line_offset at 8 (the last two Q16.16). Write
//   it only while no transaction is in flight. pready is always high.
//   Points enter on the in_ channel (in_valid / in_stall) as point_x and
//   point_y. Each point gives exactly one result on the out_ channel: the foot
//   of the perpendicular (foot_x, foot_y) and the distance to it.
//   The point passes 78 register stages, the first loaded at the accepting
//   edge: 5 to form the numerators, 34 for the bit-per-stage divider, 4 to
//   round the foot and square the offsets, 34 for the square root (one root
//   bit per stage), and the output register. The block takes one point per
//   cycle while in_stall is low.
//   When the receiver stalls, the result holds in the output register and the
//   pipeline keeps accepting points until its last stage is occupied; then
//   in_stall rises and every stage holds, so nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears the registers to a horizontal line
//   through the origin and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module point_to_line_projection
  import ptlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // Divider step: shift in one numerator bit, subtract when it fits.
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic nb,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W-1:0] t;
    logic [DEN_W-1:0] d;
    logic             ge;
    t  = {rem, nb};
    d  = t - den;
    ge = (t >= den);
    div_step = {ge, ge ? d[REM_W-1:0] : t[REM_W-1:0]};
  endfunction

  // Square root step: bring in two bits of the radicand, try the next root bit.
  function automatic logic [SREM_W+ROOT_W-1:0] sqrt_step(input logic [SREM_W-1:0] rem,
                                                         input logic [ROOT_W-1:0] root,
                                                         input logic [1:0] pair);
    logic [SREM_W-1:0] t;
    logic [SREM_W-1:0] trial;
    logic              ge;
    t     = {rem[SREM_W-3:0], pair};
    trial = {1'b0, root, 2'b01};
    ge    = (t >= trial);
    sqrt_step = {(ge ? (t - trial) : t), root[ROOT_W-2:0], ge};
  endfunction

  // Rounded quotient magnitude to a saturated signed 32-bit coordinate.
  function automatic logic [31:0] sat_coord(input logic [QB:0] q, input logic neg,
                                            input logic ovf);
    logic [QB:0] nq;
    nq = ~q + (QB+1)'(1);
    if (neg) begin
      sat_coord = (ovf || (q > (QB+1)'(34'h0_8000_0000))) ? 32'h8000_0000 : nq[31:0];
    end else begin
      sat_coord = (ovf || (q > (QB+1)'(34'h0_7FFF_FFFF))) ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic               line_vertical_r;
  logic signed [31:0] line_slope_r;
  logic signed [31:0] line_offset_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[CFG_AW-1:2]);

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vertical_r <= 1'b0;
      line_slope_r    <= '0;
      line_offset_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VERTICAL: line_vertical_r <= cfg_pwdata[0];
        REG_SLOPE:    line_slope_r    <= cfg_pwdata;
        REG_OFFSET:   line_offset_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_idx)
      REG_VERTICAL: cfg_prdata = {31'd0, line_vertical_r};
      REG_SLOPE:    cfg_prdata = line_slope_r;
      REG_OFFSET:   cfg_prdata = line_offset_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // Slope squared and the divisor follow the slope register, registered in msq_r and then den_r.
  logic [31:0]      slope_mag;
  logic [63:0]      msq_full;
  logic [62:0]      msq_r;
  logic [DEN_W-1:0] den_r;

  assign slope_mag = line_slope_r[31] ? (~line_slope_r + 32'd1) : line_slope_r;
  assign msq_full  = 64'(slope_mag) * 64'(slope_mag);

  always_ff @(posedge clk) begin
    msq_r <= msq_full[62:0];
    den_r <= {1'b0, msq_r} + (DEN_W'(1) << (2 * FRAC_BITS));
  end

  // ---------------------------------------------------------------------
  // Pipeline control: valid bits travel with the data, one global advance.
  // ---------------------------------------------------------------------
  logic [N_STAGES-1:0] v_r;
  logic                en;
  logic                out_valid_r;
  logic                out_load;
  out_item_t           out_r;

  assign en        = !v_r[N_STAGES-1] || !out_valid_r || !out_stall;
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[N_STAGES-2:0], in_valid};
      end
      if (en && out_load) begin
        out_valid_r <= v_r[N_STAGES-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Front stages: numerators of the foot coordinates.
  // ---------------------------------------------------------------------
  logic signed [31:0]      x_a_r, y_a_r;
  logic signed [32:0]      ymb_a_r;
  logic signed [31:0]      x_b_r, y_b_r;
  logic signed [64:0]      mymb_b_r;
  logic signed [63:0]      mx_b_r;
  logic signed [64:0]      pl_b_r;
  logic signed [62:0]      ph_b_r;
  logic signed [31:0]      x_c_r, y_c_r;
  logic signed [NUM_W-1:0] nx_c_r, nya_c_r, nyb_c_r;
  logic signed [31:0]      x_d_r, y_d_r;
  logic signed [NUM_W-1:0] nx_d_r, ny_d_r;
  logic signed [31:0]      x_e_r, y_e_r;
  logic [NUM_W-1:0]        nxm_e_r, nym_e_r;
  logic                    negx_e_r, negy_e_r;

  logic signed [NUM_W-1:0] w_mymb, w_x, w_ph, w_pl, w_mx, w_b;
  logic signed [NUM_W-1:0] nx_c_nxt, nya_c_nxt, nyb_c_nxt;

  // Sum terms of the numerators, widened with sign before shifting.
  always_comb begin
    w_mymb    = NUM_W'(mymb_b_r);
    w_x       = NUM_W'(x_b_r);
    w_ph      = NUM_W'(ph_b_r);
    w_pl      = NUM_W'(pl_b_r);
    w_mx      = NUM_W'(mx_b_r);
    w_b       = NUM_W'(line_offset_r);
    nx_c_nxt  = (w_mymb <<< FRAC_BITS) + (w_x <<< (2 * FRAC_BITS));
    nya_c_nxt = (w_ph <<< MSQ_SPLIT) + w_pl;
    nyb_c_nxt = (w_mx <<< FRAC_BITS) + (w_b <<< (2 * FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A: capture the point, form y - b.
      x_a_r    <= in_data.point_x;
      y_a_r    <= in_data.point_y;
      ymb_a_r  <= {in_data.point_y[31], in_data.point_y} -
                  {line_offset_r[31], line_offset_r};
      // B: products, slope squared split in two halves for y.
      x_b_r    <= x_a_r;
      y_b_r    <= y_a_r;
      mymb_b_r <= 65'(line_slope_r) * 65'(ymb_a_r);
      mx_b_r   <= 64'(line_slope_r) * 64'(x_a_r);
      pl_b_r   <= 65'($signed({1'b0, msq_r[MSQ_SPLIT-1:0]})) * 65'(y_a_r);
      ph_b_r   <= 63'($signed({1'b0, msq_r[62:MSQ_SPLIT]})) * 63'(y_a_r);
      // C: shifted partial sums.
      x_c_r    <= x_b_r;
      y_c_r    <= y_b_r;
      nx_c_r   <= nx_c_nxt;
      nya_c_r  <= nya_c_nxt;
      nyb_c_r  <= nyb_c_nxt;
      // D: final y numerator.
      x_d_r    <= x_c_r;
      y_d_r    <= y_c_r;
      nx_d_r   <= nx_c_r;
      ny_d_r   <= nya_c_r + nyb_c_r;
      // E: sign and magnitude.
      x_e_r    <= x_d_r;
      y_e_r    <= y_d_r;
      negx_e_r <= nx_d_r[NUM_W-1];
      negy_e_r <= ny_d_r[NUM_W-1];
      nxm_e_r  <= nx_d_r[NUM_W-1] ? (~nx_d_r + NUM_W'(1)) : nx_d_r;
      nym_e_r  <= ny_d_r[NUM_W-1] ? (~ny_d_r + NUM_W'(1)) : ny_d_r;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: load stage (index 0) then one quotient bit per stage.
  // ---------------------------------------------------------------------
  logic [REM_W-1:0]   drx_r [QB+1];
  logic [REM_W-1:0]   dry_r [QB+1];
  logic [QB-1:0]      dqx_r [QB+1];
  logic [QB-1:0]      dqy_r [QB+1];
  logic [QB-1:0]      dnx_r [QB+1];
  logic [QB-1:0]      dny_r [QB+1];
  logic               dnegx_r [QB+1];
  logic               dnegy_r [QB+1];
  logic               dovx_r [QB+1];
  logic               dovy_r [QB+1];
  logic signed [31:0] dpx_r [QB+1];
  logic signed [31:0] dpy_r [QB+1];
  logic [REM_W:0]     dsx [QB+1];
  logic [REM_W:0]     dsy [QB+1];

  // Step results of every divider stage.
  always_comb begin
    dsx[0] = '0;
    dsy[0] = '0;
    for (int k = 1; k <= QB; k++) begin
      dsx[k] = div_step(drx_r[k-1], dnx_r[k-1][QB-1], den_r);
      dsy[k] = div_step(dry_r[k-1], dny_r[k-1][QB-1], den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Load: quotients of 2^33 or more saturate regardless of the rest.
      drx_r[0]   <= nxm_e_r[NUM_W-1:QB];
      dry_r[0]   <= nym_e_r[NUM_W-1:QB];
      dnx_r[0]   <= nxm_e_r[QB-1:0];
      dny_r[0]   <= nym_e_r[QB-1:0];
      dqx_r[0]   <= '0;
      dqy_r[0]   <= '0;
      dovx_r[0]  <= ({1'b0, nxm_e_r[NUM_W-1:QB]} >= den_r);
      dovy_r[0]  <= ({1'b0, nym_e_r[NUM_W-1:QB]} >= den_r);
      dnegx_r[0] <= negx_e_r;
      dnegy_r[0] <= negy_e_r;
      dpx_r[0]   <= x_e_r;
      dpy_r[0]   <= y_e_r;
      for (int k = 1; k <= QB; k++) begin
        drx_r[k]   <= dsx[k][REM_W-1:0];
        dry_r[k]   <= dsy[k][REM_W-1:0];
        dqx_r[k]   <= {dqx_r[k-1][QB-2:0], dsx[k][REM_W]};
        dqy_r[k]   <= {dqy_r[k-1][QB-2:0], dsy[k][REM_W]};
        dnx_r[k]   <= {dnx_r[k-1][QB-2:0], 1'b0};
        dny_r[k]   <= {dny_r[k-1][QB-2:0], 1'b0};
        dovx_r[k]  <= dovx_r[k-1];
        dovy_r[k]  <= dovy_r[k-1];
        dnegx_r[k] <= dnegx_r[k-1];
        dnegy_r[k] <= dnegy_r[k-1];
        dpx_r[k]   <= dpx_r[k-1];
        dpy_r[k]   <= dpy_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Rounding of the foot, vertical line, offsets and their squares.
  // ---------------------------------------------------------------------
  logic [QB:0]        qx_r1_r, qy_r1_r;
  logic               negx_r1_r, negy_r1_r, ovx_r1_r, ovy_r1_r;
  logic signed [31:0] px_r1_r, py_r1_r;
  logic signed [31:0] fx_r2_r, fy_r2_r, px_r2_r, py_r2_r;
  logic signed [31:0] fx_g_r, fy_g_r;
  logic signed [32:0] ddx_g_r, ddy_g_r;
  logic signed [31:0] fx_h_r, fy_h_r;
  logic signed [65:0] sqx_h_r, sqy_h_r;
  logic               rndx, rndy;

  // Round half away from zero on the magnitude: twice the remainder reaches
  // the divisor.
  assign rndx = ({drx_r[QB], 1'b0} >= den_r);
  assign rndy = ({dry_r[QB], 1'b0} >= den_r);

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r1_r   <= {1'b0, dqx_r[QB]} + (QB+1)'(rndx);
      qy_r1_r   <= {1'b0, dqy_r[QB]} + (QB+1)'(rndy);
      negx_r1_r <= dnegx_r[QB];
      negy_r1_r <= dnegy_r[QB];
      ovx_r1_r  <= dovx_r[QB];
      ovy_r1_r  <= dovy_r[QB];
      px_r1_r   <= dpx_r[QB];
      py_r1_r   <= dpy_r[QB];
      // Vertical line: x is minus the offset, y passes straight through.
      if (line_vertical_r) begin
        fx_r2_r <= (line_offset_r == 32'sh8000_0000) ? 32'sh7FFF_FFFF :
                   (~line_offset_r + 32'sd1);
        fy_r2_r <= py_r1_r;
      end else begin
        fx_r2_r <= sat_coord(qx_r1_r, negx_r1_r, ovx_r1_r);
        fy_r2_r <= sat_coord(qy_r1_r, negy_r1_r, ovy_r1_r);
      end
      px_r2_r   <= px_r1_r;
      py_r2_r   <= py_r1_r;
      // Offsets from the foot to the point.
      fx_g_r    <= fx_r2_r;
      fy_g_r    <= fy_r2_r;
      ddx_g_r   <= {px_r2_r[31], px_r2_r} - {fx_r2_r[31], fx_r2_r};
      ddy_g_r   <= {py_r2_r[31], py_r2_r} - {fy_r2_r[31], fy_r2_r};
      // Squares.
      fx_h_r    <= fx_g_r;
      fy_h_r    <= fy_g_r;
      sqx_h_r   <= 66'(ddx_g_r) * 66'(ddx_g_r);
      sqy_h_r   <= 66'(ddy_g_r) * 66'(ddy_g_r);
    end
  end

  // ---------------------------------------------------------------------
  // Square root: load stage (sum) then one root bit per stage.
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]   ssum_r [SQ+1];
  logic [SREM_W-1:0]  srem_r [SQ+1];
  logic [ROOT_W-1:0]  sroot_r [SQ+1];
  logic signed [31:0] sfx_r [SQ+1];
  logic signed [31:0] sfy_r [SQ+1];
  logic [SREM_W+ROOT_W-1:0] sst [SQ+1];

  always_comb begin
    sst[0] = '0;
    for (int k = 1; k <= SQ; k++) begin
      sst[k] = sqrt_step(srem_r[k-1], sroot_r[k-1], ssum_r[k-1][SUM_W-1 -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ssum_r[0]  <= sqx_h_r[SUM_W-1:0] + sqy_h_r[SUM_W-1:0];
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sfx_r[0]   <= fx_h_r;
      sfy_r[0]   <= fy_h_r;
      for (int k = 1; k <= SQ; k++) begin
        ssum_r[k]  <= {ssum_r[k-1][SUM_W-3:0], 2'b00};
        srem_r[k]  <= sst[k][SREM_W+ROOT_W-1:ROOT_W];
        sroot_r[k] <= sst[k][ROOT_W-1:0];
        sfx_r[k]   <= sfx_r[k-1];
        sfy_r[k]   <= sfy_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: round the root to nearest and saturate.
  // ---------------------------------------------------------------------
  logic [ROOT_W:0] dist_rnd;

  assign dist_rnd = {1'b0, sroot_r[SQ]} +
                    (ROOT_W+1)'(srem_r[SQ] > SREM_W'(sroot_r[SQ]));

  always_ff @(posedge clk) begin
    if (en && out_load) begin
      out_r.foot_x         <= sfx_r[SQ];
      out_r.foot_y         <= sfy_r[SQ];
      out_r.point_distance <= (dist_rnd > (ROOT_W+1)'(34'h0_FFFF_FFFF)) ?
                              32'hFFFF_FFFF : dist_rnd[31:0];
    end
  end

endmodule

`default_nettype wire

/* src/ptlp_checker.sv */
// Port-level checker for point_to_line_projection, attached by bind.
// Depends on ptlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptlp_checker
  import ptlp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled result stays offered.
  `PTLP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `PTLP_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")

  // With the output register empty the block always takes a transaction.
  `PTLP_ASSERT(a_in_open, clk, rst_n, !out_valid |-> !in_stall, "input stalled with empty output")

  // Reset empties the block and opens the input.
  `PTLP_ASSERT_ANY(a_rst_idle, clk, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind point_to_line_projection ptlp_checker u_ptlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for point_to_line_projection: random and directed
// points under several line settings, with a scoreboard that predicts each result.
// Depends on ptlp_pkg and the point_to_line_projection RTL.
`timescale 1ns / 1ps

module testbench;
  import ptlp_pkg::*;

  // Predicts the projection of each accepted point and checks the results in order.
  class projection_scoreboard;
    bit                 line_vert;
    logic signed [31:0] line_m;
    logic signed [31:0] line_b;
    out_item_t          pending[$];
    int                 errors;

    function new();
      line_vert = 0;
      line_m    = 0;
      line_b    = 0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_VERTICAL: line_vert = val[0];
        REG_SLOPE:    line_m    = val;
        REG_OFFSET:   line_b    = val;
        default: ;
      endcase
    endfunction

    // Rounds num/den to nearest (halves away from zero) and saturates to 32 bits.
    function longint div_round_sat(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] mag;
      logic signed [127:0] quo;
      logic signed [127:0] rem;
      mag = (num < 0) ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if (rem >= den - rem) quo = quo + 1;
      if (num < 0) begin
        if (quo > 128'sh80000000) return -64'sh80000000;
        return -longint'(quo);
      end
      if (quo > 128'sh7FFFFFFF) return 64'sh7FFFFFFF;
      return longint'(quo);
    endfunction

    // Rounded distance from the point to the foot, saturated to 32 bits.
    function logic [31:0] distance(longint dx, longint dy);
      logic signed [127:0] sum;
      logic signed [127:0] root;
      logic signed [127:0] cand;
      sum  = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      root = 0;
      for (int bitpos = 33; bitpos >= 0; bitpos--) begin
        cand = root | (128'sd1 << bitpos);
        if (cand * cand <= sum) root = cand;
      end
      if (sum - root * root > root) root = root + 1;
      if (root > 128'shFFFFFFFF) return 32'hFFFFFFFF;
      return root[31:0];
    endfunction

    function void note_point(in_item_t pt);
      logic signed [127:0] x, y, m, b, msq, den, nx, ny;
      longint              fx, fy;
      out_item_t           res;
      x = 128'($signed(pt.point_x));
      y = 128'($signed(pt.point_y));
      m = 128'(line_m);
      b = 128'(line_b);
      if (line_vert) begin
        fx = -longint'(line_b);
        if (fx > 64'sh7FFFFFFF) fx = 64'sh7FFFFFFF;
        fy = longint'(y);
      end else begin
        msq = m * m;
        den = msq + (128'sd1 <<< (2 * FRAC_BITS));
        nx  = ((m * (y - b)) <<< FRAC_BITS) + (x <<< (2 * FRAC_BITS));
        ny  = msq * y + ((m * x) <<< FRAC_BITS) + (b <<< (2 * FRAC_BITS));
        fx  = div_round_sat(nx, den);
        fy  = div_round_sat(ny, den);
      end
      res.foot_x         = fx[31:0];
      res.foot_y         = fy[31:0];
      res.point_distance = distance(longint'(x) - fx, longint'(y) - fy);
      pending.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = pending.pop_front();
      if (got.foot_x !== exp.foot_x)
        report($sformatf("foot_x got %h exp %h", got.foot_x, exp.foot_x));
      if (got.foot_y !== exp.foot_y)
        report($sformatf("foot_y got %h exp %h", got.foot_y, exp.foot_y));
      if (got.point_distance !== exp.point_distance)
        report($sformatf("distance got %h exp %h", got.point_distance,
                         exp.point_distance));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  projection_scoreboard sb = new();
  int  points_sent;
  bit  pressure_req;
  int  hold_left;
  bit  pressure_done;

  point_to_line_projection u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock with a 20 ns period.
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Idle rates move through three regimes as the run progresses.
  function int sender_idle_pct();
    if (points_sent < 233) return 36;
    if (points_sent < 466) return 73;
    return 0;
  endfunction

  function int receiver_idle_pct();
    if (points_sent < 233) return 73;
    if (points_sent < 466) return 36;
    return 0;
  endfunction

  // Result side: check each accepted transaction, then choose the next stall.
  // A pressure request holds the output off long enough to back up the pipeline.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else if (pressure_req && !pressure_done) begin
      pressure_done <= 1;
      hold_left     <= 400;
      out_stall     <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= 1;
    cfg_paddr   <= CFG_AW'(idx) << 2;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    sb.set_reg(idx, val);
  endtask

  // Offers one point, with an optional gap before it, until it is accepted.
  task send_point(logic [31:0] px, logic [31:0] py);
    in_item_t pt;
    int       gap;
    if ($urandom_range(0, 99) < sender_idle_pct()) begin
      gap = $urandom_range(1, 5);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pt.point_x = px;
    pt.point_y = py;
    in_valid <= 1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(pt);
    points_sent++;
  endtask

  // Random coordinate: full range, small, extreme, or near zero.
  function logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2 ** 17)) - 2 ** 16);
    endcase
  endfunction

  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // Line settings, extremes included: vertical/slope/offset per phase.
  logic [31:0] line_cfg[8][3] = '{
    '{32'd0, 32'h00000000, 32'h00000000},
    '{32'd1, 32'h00010000, 32'h80000000},
    '{32'd1, 32'h7FFFFFFF, 32'h7FFFFFFF},
    '{32'd0, 32'h00010000, 32'h00000000},
    '{32'd0, 32'h7FFFFFFF, 32'h80000000},
    '{32'd0, 32'h80000000, 32'h7FFFFFFF},
    '{32'd0, 32'hFFFF8000, 32'h00123456},
    '{32'd0, 32'h00024000, 32'hFFF00000}
  };

  logic [31:0] corner_pts[10][2] = '{
    '{32'h00000000, 32'h00000000},
    '{32'h7FFFFFFF, 32'h7FFFFFFF},
    '{32'h80000000, 32'h80000000},
    '{32'h7FFFFFFF, 32'h80000000},
    '{32'h80000000, 32'h7FFFFFFF},
    '{32'h00010000, 32'hFFFF0000},
    '{32'hFFFFFFFF, 32'h00000001},
    '{32'h00008000, 32'h00008000},
    '{32'hAAAAAAAA, 32'h55555555},
    '{32'h55555555, 32'hAAAAAAAA}
  };

  // Main stimulus: reset, then one phase per line setting.
  initial begin
    rst_n        = 0;
    in_valid     = 0;
    in_data      = '0;
    cfg_psel     = 0;
    cfg_penable  = 0;
    cfg_pwrite   = 0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    points_sent  = 0;
    pressure_req = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_VERTICAL, line_cfg[ph][0]);
      write_reg(REG_SLOPE, line_cfg[ph][1]);
      write_reg(REG_OFFSET, line_cfg[ph][2]);
      if (ph == 3) pressure_req <= 1;
      for (int i = 0; i < (ph == 0 ? 10 : 3); i++)
        send_point(corner_pts[i][0], corner_pts[i][1]);
      for (int i = 0; i < 85; i++) send_point(rand_coord(), rand_coord());
      in_valid <= 0;
      wait_drained();
    end
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
